FILE: sv/rhc_pkg.sv
// shared types and constants for the rgb to hsv converter
package rhc_pkg;

    localparam int CHAN_W          = 8;
    localparam int QUO_W           = 9;
    localparam int HUE_W           = 9;
    localparam int SUM_W           = 12;
    localparam int PROD_W          = 18;
    localparam int HDIV_W          = PROD_W - 8;

    // saturation and distances are scaled so that this value means full
    localparam int SCALE           = 256;
    localparam int SCALE_LOG2      = 8;

    // restoring division: one quotient bit per step
    localparam int DIV_STEPS       = QUO_W;
    localparam int STEPS_PER_STAGE = 3;
    localparam int DIV_STAGES      = DIV_STEPS / STEPS_PER_STAGE;

    localparam logic signed [SUM_W-1:0]  OFFSET_GREEN = SUM_W'(2 * SCALE);
    localparam logic signed [SUM_W-1:0]  OFFSET_BLUE  = SUM_W'(4 * SCALE);
    localparam logic signed [PROD_W-1:0] HUE_MUL      = PROD_W'(60);
    localparam logic signed [PROD_W-1:0] TRUNC_BIAS   = PROD_W'(SCALE - 1);
    localparam logic signed [HDIV_W-1:0] HUE_WRAP     = HDIV_W'(360);
    localparam logic signed [HDIV_W-1:0] HUE_MAX      = HDIV_W'(359);

    // divider lanes
    localparam int LANE_SAT   = 0;
    localparam int LANE_RED   = 1;
    localparam int LANE_GREEN = 2;
    localparam int LANE_BLUE  = 3;
    localparam int NUM_LANES  = 4;

    // which channel holds the maximum
    typedef enum logic [1:0] {
        SEL_RED,
        SEL_GREEN,
        SEL_BLUE
    } max_sel_t;

    typedef struct packed {
        logic [CHAN_W-1:0] rem;
        logic              lsb;
        logic [QUO_W-1:0]  quo;
    } div_lane_t;

    typedef struct packed {
        logic [CHAN_W-1:0]                hi;
        logic [CHAN_W-1:0]                span;
        logic                             grey;
        max_sel_t                         sel;
        div_lane_t [NUM_LANES-1:0]        lane;
    } div_work_t;

endpackage

FILE: sv/rgb_to_hsv_convert.sv
// top level of the pipelined rgb to hsv pixel converter
//
// usage
//   pixel channel: red_in, green_in, blue_in with pixel_valid; the block
//   drives pixel_stall. a transfer happens on a rising edge with
//   pixel_valid high and pixel_stall low
//   result channel: hue_deg (0..359, 0 for grey), sat_level (256 is full)
//   and val_level (largest channel) with result_valid; the sink drives
//   result_stall. a transfer happens with result_valid high and
//   result_stall low
//   a pixel passes from its transfer to its result being shown through
//   six register stages: front end, three divider stages of three
//   quotient bits each, the hue multiply and the output register; every
//   stage takes a new transfer as it empties, so one pixel per clock is
//   taken in steady state while result_stall stays low
//   reset clears every stage valid bit, so the pipe starts empty
//   when the sink stalls, each stage holds only if the one after it is
//   full and held, so bubbles close up and pixel_stall rises only once
//   all six stages are occupied; nothing is dropped or repeated
module rgb_to_hsv_convert
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       pixel_valid,
    output logic                       pixel_stall,
    input  logic [rhc_pkg::CHAN_W-1:0] red_in,
    input  logic [rhc_pkg::CHAN_W-1:0] green_in,
    input  logic [rhc_pkg::CHAN_W-1:0] blue_in,
    output logic                       result_valid,
    input  logic                       result_stall,
    output logic [rhc_pkg::HUE_W-1:0]  hue_deg,
    output logic [rhc_pkg::QUO_W-1:0]  sat_level,
    output logic [rhc_pkg::CHAN_W-1:0] val_level
);
    import rhc_pkg::*;

    logic      front_ready;
    // handshake and work bundle between consecutive stages
    logic      div_valid [DIV_STAGES+1];
    logic      div_ready [DIV_STAGES+1];
    div_work_t div_data  [DIV_STAGES+1];

    assign pixel_stall = !front_ready;

    // max / min / span and lane set-up
    rhc_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pixel_valid),
        .in_ready  (front_ready),
        .red       (red_in),
        .green     (green_in),
        .blue      (blue_in),
        .out_valid (div_valid[0]),
        .out_ready (div_ready[0]),
        .out_data  (div_data[0])
    );

    // divider chain: saturation and the three channel distances in parallel
    for (genvar i = 0; i < DIV_STAGES; i++)
    begin : g_div
        rhc_div_stage
        #(
            .STEPS (STEPS_PER_STAGE)
        )
        u_div
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (div_valid[i]),
            .in_ready  (div_ready[i]),
            .in_data   (div_data[i]),
            .out_valid (div_valid[i+1]),
            .out_ready (div_ready[i+1]),
            .out_data  (div_data[i+1])
        );
    end

    // hue combine, scale to degrees and output register
    rhc_hue_stage u_hue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_valid[DIV_STAGES]),
        .in_ready  (div_ready[DIV_STAGES]),
        .in_data   (div_data[DIV_STAGES]),
        .out_valid (result_valid),
        .out_ready (!result_stall),
        .hue       (hue_deg),
        .sat       (sat_level),
        .val       (val_level)
    );

endmodule

FILE: sv/rhc_front.sv
// first stage: max, min, span and divider lane set-up
module rhc_front
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [rhc_pkg::CHAN_W-1:0] red,
    input  logic [rhc_pkg::CHAN_W-1:0] green,
    input  logic [rhc_pkg::CHAN_W-1:0] blue,
    output logic                       out_valid,
    input  logic                       out_ready,
    output rhc_pkg::div_work_t         out_data
);
    import rhc_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    div_work_t         data_reg;
    div_work_t         data_next;
    logic [CHAN_W-1:0] lo;
    logic [CHAN_W-1:0] num [NUM_LANES];

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_comb
    begin
        data_next = '0;
        // ties go to red, then green
        if (red >= green && red >= blue)
        begin
            data_next.sel = SEL_RED;
            data_next.hi  = red;
        end
        else if (green >= blue)
        begin
            data_next.sel = SEL_GREEN;
            data_next.hi  = green;
        end
        else
        begin
            data_next.sel = SEL_BLUE;
            data_next.hi  = blue;
        end

        if (red <= green && red <= blue)
            lo = red;
        else if (green <= blue)
            lo = green;
        else
            lo = blue;

        data_next.span = data_next.hi - lo;
        data_next.grey = (data_next.hi == lo);

        num[LANE_SAT]   = data_next.span;
        num[LANE_RED]   = data_next.hi - red;
        num[LANE_GREEN] = data_next.hi - green;
        num[LANE_BLUE]  = data_next.hi - blue;

        // dividend is num * scale, so the first partial remainder is num / 2
        for (int l = 0; l < NUM_LANES; l++)
        begin
            data_next.lane[l].rem = {1'b0, num[l][CHAN_W-1:1]};
            data_next.lane[l].lsb = num[l][0];
            data_next.lane[l].quo = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: sv/rhc_div_stage.sv
// one pipeline stage of the four-lane restoring divider
module rhc_div_stage
#(
    parameter int STEPS = 3
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  rhc_pkg::div_work_t in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output rhc_pkg::div_work_t out_data
);
    import rhc_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    div_work_t data_reg;
    div_work_t data_next;

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_comb
    begin
        logic [CHAN_W:0]   trial;
        logic [CHAN_W-1:0] den;
        data_next = in_data;
        for (int l = 0; l < NUM_LANES; l++)
        begin
            // saturation divides by max, the distances by the span
            den = (l == LANE_SAT) ? in_data.hi : in_data.span;
            for (int s = 0; s < STEPS; s++)
            begin
                trial = {data_next.lane[l].rem, data_next.lane[l].lsb};
                if (trial >= {1'b0, den})
                begin
                    data_next.lane[l].rem = CHAN_W'(trial - {1'b0, den});
                    data_next.lane[l].quo = {data_next.lane[l].quo[QUO_W-2:0], 1'b1};
                end
                else
                begin
                    data_next.lane[l].rem = trial[CHAN_W-1:0];
                    data_next.lane[l].quo = {data_next.lane[l].quo[QUO_W-2:0], 1'b0};
                end
                data_next.lane[l].lsb = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: sv/rhc_hue_stage.sv
// hue sum and multiply stage, then scale-down, wrap and output register
module rhc_hue_stage
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  rhc_pkg::div_work_t         in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [rhc_pkg::HUE_W-1:0]  hue,
    output logic [rhc_pkg::QUO_W-1:0]  sat,
    output logic [rhc_pkg::CHAN_W-1:0] val
);
    import rhc_pkg::*;

    // multiply stage
    logic                     mul_valid_reg;
    logic                     mul_valid_next;
    logic                     mul_ready;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic [QUO_W-1:0]         msat_reg;
    logic [CHAN_W-1:0]        mhi_reg;
    logic                     mgrey_reg;
    logic signed [SUM_W-1:0]  dist_r;
    logic signed [SUM_W-1:0]  dist_g;
    logic signed [SUM_W-1:0]  dist_b;
    logic signed [SUM_W-1:0]  sum;

    // output stage
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic signed [PROD_W-1:0] biased;
    logic signed [HDIV_W-1:0] hdiv;
    logic signed [HDIV_W-1:0] hwrap;
    logic [HUE_W-1:0]         hue_reg;
    logic [HUE_W-1:0]         hue_next;
    logic [QUO_W-1:0]         sat_reg;
    logic [QUO_W-1:0]         sat_next;
    logic [CHAN_W-1:0]        val_reg;

    assign mul_ready      = !out_valid_reg || out_ready;
    assign in_ready       = !mul_valid_reg || mul_ready;
    assign mul_valid_next = in_ready ? in_valid : mul_valid_reg;
    assign out_valid_next = mul_ready ? mul_valid_reg : out_valid_reg;

    always_comb
    begin
        dist_r = SUM_W'(in_data.lane[LANE_RED].quo);
        dist_g = SUM_W'(in_data.lane[LANE_GREEN].quo);
        dist_b = SUM_W'(in_data.lane[LANE_BLUE].quo);
        unique case (in_data.sel)
            SEL_RED:   sum = dist_b - dist_g;
            SEL_GREEN: sum = OFFSET_GREEN + dist_r - dist_b;
            SEL_BLUE:  sum = OFFSET_BLUE + dist_g - dist_r;
            default:   sum = '0;
        endcase
        prod_next = PROD_W'(sum) * HUE_MUL;
    end

    // divide by scale rounding toward zero, then wrap into a full turn
    always_comb
    begin
        biased = prod_reg[PROD_W-1] ? (prod_reg + TRUNC_BIAS) : prod_reg;
        hdiv   = HDIV_W'(biased >>> SCALE_LOG2);
        if (hdiv < 0)
            hwrap = hdiv + HUE_WRAP;
        else if (hdiv > HUE_MAX)
            hwrap = hdiv - HUE_WRAP;
        else
            hwrap = hdiv;

        if (mgrey_reg)
        begin
            hue_next = '0;
            sat_next = '0;
        end
        else
        begin
            hue_next = hwrap[HUE_W-1:0];
            sat_next = msat_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mul_valid_reg <= mul_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            prod_reg  <= prod_next;
            msat_reg  <= in_data.lane[LANE_SAT].quo;
            mhi_reg   <= in_data.hi;
            mgrey_reg <= in_data.grey;
        end
        if (mul_valid_reg && mul_ready)
        begin
            hue_reg <= hue_next;
            sat_reg <= sat_next;
            val_reg <= mhi_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign hue       = hue_reg;
    assign sat       = sat_reg;
    assign val       = val_reg;

endmodule
